@@ hdl/rtphp_pkg.sv @@
package rtphp_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 2048;

  // fixed header fields
  localparam int HDR_BYTES   = 12;
  localparam int WORD_BYTES  = 4;
  localparam int RTP_VERSION = 2;
  localparam int PAD_BIT     = 5;  // bit index of P in first byte
  localparam int EXT_BIT     = 4;  // bit index of X in first byte

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_PADDING  = 3'd3,
    ST_CSRC     = 3'd4,
    ST_EXT_HDR  = 3'd5,
    ST_EXT_BODY = 3'd6,
    ST_OVERSIZE = 3'd7
  } status_t;

  typedef struct packed {
    logic        ext;
    logic [3:0]  csrc_count;
    logic [7:0]  padding_length;
    logic [11:0] payload_length;
    logic [11:0] payload_offset;
    status_t     status;
  } result_t;

endpackage

@@ hdl/rtp_header_parser.sv @@
// RTP header parser.
// Slave stream (s_*): one packet byte per beat, s_tlast on the final byte.
// Master stream (m_*): one result beat per packet, issued for the beat that
// carried s_tlast; beats without s_tlast produce nothing.
// Pipeline: the input stage updates the running packet state (byte count,
// first header byte, the two extension-length bytes) and, on the last byte,
// latches a snapshot of it. The next stage evaluates the header checks from
// that snapshot into the output register. m_tvalid rises when the snapshot
// moves into the output register, so a result passes the snapshot and the
// output register before it can be taken.
// Throughput: one byte per cycle, sustained, also while a result waits on
// m_tready, as long as the snapshot stage is free; both stages advance
// together when the output register drains.
// Stall: if m_tready stays low with a result held and a second last byte is
// latched in the snapshot stage, s_tready drops until the result is taken.
// Reset (rst, synchronous): clears the packet state and both valid flags.
// The byte count saturates one above MAX_PACKET_BYTES, which flags oversize.
module rtp_header_parser #(
  parameter int MAX_PACKET_BYTES = rtphp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rtphp_pkg::IN_DATA_W-1:0] s_tdata,  // [7:0] data_byte
  input  logic                            s_tlast,  // last_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [2:0] status, [14:3] payload_offset, [26:15] payload_length,
  // [34:27] padding_length, [38:35] csrc_count, [39] extension_present
  output logic [rtphp_pkg::OUT_DATA_W-1:0] m_tdata
);

  // count must hold MAX_PACKET_BYTES + 1
  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
  // compare width: offset + 4 + 4*ext_len needs 19 bits
  localparam int CMP_W = (CNT_W > 19) ? CNT_W + 1 : 20;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

  // ---------------- input stage: running packet state ----------------
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       first_header_byte, first_header_byte_next;
  logic [7:0]       ext_length_high, ext_length_high_next;
  logic [7:0]       ext_length_low, ext_length_low_next;

  logic             in_beat;
  logic             out_ready;
  logic             snap_ready;
  logic [6:0]       hdr_end;       // 12 + 4*CC
  logic [CNT_W-1:0] count_inc;

  // snapshot of a finished packet
  logic             snap_valid;
  logic [CNT_W-1:0] snap_size;
  logic [7:0]       snap_hdr;
  logic [7:0]       snap_last;
  logic [15:0]      snap_ext_len;

  assign out_ready  = !m_tvalid || m_tready;
  assign snap_ready = !snap_valid || out_ready;
  assign s_tready   = snap_ready;
  assign in_beat    = s_tvalid && s_tready;

  always_comb begin
    first_header_byte_next = (byte_count == '0) ? s_tdata : first_header_byte;
    hdr_end   = 7'(rtphp_pkg::HDR_BYTES) + {1'b0, first_header_byte_next[3:0], 2'b00};
    count_inc = (byte_count <= MAX_CNT) ? byte_count + 1'b1 : byte_count;
    ext_length_high_next = ext_length_high;
    ext_length_low_next  = ext_length_low;
    if (CMP_W'(byte_count) == CMP_W'(hdr_end) + CMP_W'(2)) begin
      ext_length_high_next = s_tdata;
    end
    if (CMP_W'(byte_count) == CMP_W'(hdr_end) + CMP_W'(3)) begin
      ext_length_low_next = s_tdata;
    end
    byte_count_next = count_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      first_header_byte <= '0;
      ext_length_high   <= '0;
      ext_length_low    <= '0;
    end else if (in_beat) begin
      if (s_tlast) begin
        // packet done: clear for the next one
        byte_count        <= '0;
        first_header_byte <= '0;
        ext_length_high   <= '0;
        ext_length_low    <= '0;
      end else begin
        byte_count        <= byte_count_next;
        first_header_byte <= first_header_byte_next;
        ext_length_high   <= ext_length_high_next;
        ext_length_low    <= ext_length_low_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_ready) begin
      snap_valid <= in_beat && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && s_tlast) begin
      snap_size    <= byte_count_next;
      snap_hdr     <= first_header_byte_next;
      snap_last    <= s_tdata;
      snap_ext_len <= {ext_length_high_next, ext_length_low_next};
    end
  end

  // ---------------- check stage ----------------
  rtphp_pkg::result_t res, res_next;

  logic             p_bit, x_bit;
  logic [7:0]       pad;
  logic [CMP_W-1:0] size_w, red_size, off0, off_ext, off_fin;
  logic [CMP_W-1:0] pad_w, plen;

  always_comb begin
    p_bit    = snap_hdr[rtphp_pkg::PAD_BIT];
    x_bit    = snap_hdr[rtphp_pkg::EXT_BIT];
    pad      = p_bit ? snap_last : 8'd0;
    pad_w    = CMP_W'(pad);
    size_w   = CMP_W'(snap_size);
    red_size = size_w - pad_w;
    off0     = CMP_W'(rtphp_pkg::HDR_BYTES) + CMP_W'({snap_hdr[3:0], 2'b00});
    off_ext  = off0 + CMP_W'(rtphp_pkg::WORD_BYTES) + CMP_W'({snap_ext_len, 2'b00});
    off_fin  = x_bit ? off_ext : off0;
    plen     = red_size - off_fin;

    res_next.status = rtphp_pkg::ST_OK;
    if (snap_size > MAX_CNT) begin
      res_next.status = rtphp_pkg::ST_OVERSIZE;
    end else if (size_w < CMP_W'(rtphp_pkg::HDR_BYTES)) begin
      res_next.status = rtphp_pkg::ST_SHORT;
    end else if (snap_hdr[7:6] != 2'(rtphp_pkg::RTP_VERSION)) begin
      res_next.status = rtphp_pkg::ST_VERSION;
    end else if (p_bit && (pad_w + CMP_W'(rtphp_pkg::HDR_BYTES) > size_w)) begin
      res_next.status = rtphp_pkg::ST_PADDING;
    end else if (red_size < off0) begin
      res_next.status = rtphp_pkg::ST_CSRC;
    end else if (x_bit && (red_size < off0 + CMP_W'(rtphp_pkg::WORD_BYTES))) begin
      res_next.status = rtphp_pkg::ST_EXT_HDR;
    end else if (x_bit && (red_size < off_ext)) begin
      res_next.status = rtphp_pkg::ST_EXT_BODY;
    end

    if (res_next.status == rtphp_pkg::ST_OK) begin
      res_next.payload_offset = off_fin[11:0];
      res_next.payload_length = plen[11:0];
    end else begin
      res_next.payload_offset = '0;
      res_next.payload_length = '0;
    end
    res_next.padding_length = pad;
    res_next.csrc_count     = snap_hdr[3:0];
    res_next.ext            = x_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && snap_valid) begin
      res <= res_next;
    end
  end

  assign m_tdata = res;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_CNT + 1'b1)
    else $error("byte count beyond saturation point");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_tlast |=> byte_count == '0 && first_header_byte == '0)
    else $error("packet state not cleared after last byte");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status != rtphp_pkg::ST_OK |->
      res.payload_offset == '0 && res.payload_length == '0)
    else $error("error result carries offset or length");

  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !out_ready |=> snap_valid && $stable(snap_size))
    else $error("snapshot lost while output stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    snap_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken with both stages full");
`endif

endmodule

@@ verif/rtp_header_parser_checker.sv @@
// Watches both streams of the RTP header parser, predicts the result for each
// packet from the accepted bytes, and compares every result beat in order.
module rtp_header_parser_checker #(
  parameter int MAX_PACKET_BYTES = rtphp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [rtphp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                             s_tlast,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [rtphp_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                               mismatches,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // running packet state, mirrors the block's own
  int unsigned pkt_bytes;
  logic [7:0]  hdr_byte;
  logic [7:0]  ext_len_hi;
  logic [7:0]  ext_len_lo;

  rtphp_pkg::result_t pending_results[$];
  rtphp_pkg::result_t want;
  rtphp_pkg::result_t got;

  function automatic string show(rtphp_pkg::result_t r);
    return $sformatf("status=%0d offset=%0d length=%0d padding=%0d csrc=%0d ext=%0b",
                     r.status, r.payload_offset, r.payload_length,
                     r.padding_length, r.csrc_count, r.ext);
  endfunction

  function automatic void clear_packet();
    pkt_bytes  = 0;
    hdr_byte   = '0;
    ext_len_hi = '0;
    ext_len_lo = '0;
  endfunction

  // Take one packet byte; on the last byte queue the parse result.
  function automatic void absorb_byte(logic [7:0] b, logic last);
    int unsigned        idx;
    int unsigned        off;
    int unsigned        size;
    int unsigned        pad;
    int unsigned        ext_bytes;
    rtphp_pkg::status_t st;
    rtphp_pkg::result_t r;
    idx = pkt_bytes;
    if (idx == 0) hdr_byte = b;
    off = rtphp_pkg::HDR_BYTES + rtphp_pkg::WORD_BYTES * int'(hdr_byte[3:0]);
    if (idx >= 1) begin
      if (idx == off + 2) ext_len_hi = b;
      if (idx == off + 3) ext_len_lo = b;
    end
    if (idx <= MAX_PACKET_BYTES) pkt_bytes = idx + 1;
    if (!last) return;

    size = pkt_bytes;
    pad  = hdr_byte[rtphp_pkg::PAD_BIT] ? int'(b) : 0;
    st   = rtphp_pkg::ST_OK;
    if (size > MAX_PACKET_BYTES) begin
      st = rtphp_pkg::ST_OVERSIZE;
    end else if (size < rtphp_pkg::HDR_BYTES) begin
      st = rtphp_pkg::ST_SHORT;
    end else if (hdr_byte[7:6] != rtphp_pkg::RTP_VERSION) begin
      st = rtphp_pkg::ST_VERSION;
    end else if (hdr_byte[rtphp_pkg::PAD_BIT] && pad + rtphp_pkg::HDR_BYTES > size) begin
      st = rtphp_pkg::ST_PADDING;
    end else begin
      size -= pad;
      if (size < off) begin
        st = rtphp_pkg::ST_CSRC;
      end else if (hdr_byte[rtphp_pkg::EXT_BIT]) begin
        ext_bytes = rtphp_pkg::WORD_BYTES * int'({ext_len_hi, ext_len_lo});
        if (size < off + rtphp_pkg::WORD_BYTES) st = rtphp_pkg::ST_EXT_HDR;
        else if (size < off + rtphp_pkg::WORD_BYTES + ext_bytes) st = rtphp_pkg::ST_EXT_BODY;
        else off += rtphp_pkg::WORD_BYTES + ext_bytes;
      end
    end

    r.status         = st;
    r.payload_offset = (st == rtphp_pkg::ST_OK) ? 12'(off) : '0;
    r.payload_length = (st == rtphp_pkg::ST_OK) ? 12'(size - off) : '0;
    r.padding_length = 8'(pad);
    r.csrc_count     = hdr_byte[3:0];
    r.ext            = hdr_byte[rtphp_pkg::EXT_BIT];
    pending_results.push_back(r);
    clear_packet();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_packet();
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = rtphp_pkg::result_t'(m_tdata);
        if (pending_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: %s", show(got));
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status ||
              got.payload_offset !== want.payload_offset ||
              got.payload_length !== want.payload_length ||
              got.padding_length !== want.padding_length ||
              got.csrc_count !== want.csrc_count ||
              got.ext !== want.ext) begin
            if (mismatches < 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ verif/rtp_header_parser_test.sv @@
// Stimulus and verdict for the RTP header parser. The checker instance does
// all prediction and comparison; this module only builds packets, drives the
// byte stream, throttles the result stream and decides pass or fail.
module rtp_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 700;     // bytes in the random part
  localparam int CYCLE_LIMIT  = 1000000; // hard stop for a hung run
  localparam int HOLD_CYCLES  = 400;     // long result back-pressure
  localparam int DRAIN_CYCLES = 20;      // extra wait after the last result

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rtphp_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
  logic                             s_tlast = 1'b0; // last_byte
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  // [2:0] status, [14:3] payload_offset, [26:15] payload_length,
  // [34:27] padding_length, [38:35] csrc_count, [39] extension_present
  logic [rtphp_pkg::OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int tx_beats    = 0;
  int rx_hold     = 0;   // set by stimulus, consumed by the result side

  logic [7:0] pkt[$];    // packet under construction

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  rtp_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rtp_header_parser_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Build an RTP packet into pkt: fixed header, CSRC list sized by the low
  // nibble of the first byte, extension (profile, length, body) when the X bit
  // is set, payload, then padding whose last byte is its count when P is set.
  // total >= 0 trims or pads the packet to that size afterwards; tail >= 0
  // overwrites the final byte (which is what the block reads as padding).
  function automatic void build_rtp(logic [7:0] first, int ext_words, int payload,
                                    int pad, int total, int tail);
    pkt.delete();
    pkt.push_back(first);
    repeat (11) pkt.push_back(8'($urandom));
    repeat (4 * int'(first[3:0])) pkt.push_back(8'($urandom));
    if (first[rtphp_pkg::EXT_BIT]) begin
      repeat (2) pkt.push_back(8'($urandom));
      pkt.push_back(8'(ext_words >> 8));
      pkt.push_back(8'(ext_words));
      repeat (4 * ext_words) pkt.push_back(8'($urandom));
    end
    repeat (payload) pkt.push_back(8'($urandom));
    if (first[rtphp_pkg::PAD_BIT] && pad > 0) begin
      repeat (pad - 1) pkt.push_back(8'($urandom));
      pkt.push_back(8'(pad));
    end
    if (total >= 0) begin
      while (pkt.size() > total) void'(pkt.pop_back());
      while (pkt.size() < total) pkt.push_back(8'($urandom));
    end
    if (tail >= 0) pkt[pkt.size() - 1] = 8'(tail);
  endfunction

  // Drive pkt as one beat per byte, tlast on the final one. A random gap
  // precedes each beat, except during calm stretches that are
  // redrawn every 32 beats so back-to-back streaming also gets exercised.
  task automatic send_packet();
    int  gap;
    bit  calm;
    calm = 1'b0;
    for (int i = 0; i < pkt.size(); i++) begin
      if (tx_beats % 32 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= pkt[i];
      s_tlast  <= (i == pkt.size() - 1);
      do @(posedge clk); while (!s_tready);
      tx_beats++;
    end
  endtask

  task automatic send_rtp(logic [7:0] first, int ext_words, int payload,
                          int pad, int total, int tail);
    build_rtp(first, ext_words, payload, pad, total, tail);
    send_packet();
  endtask

  // Result side: per beat a random hold on tready, calm stretches
  // with none, and when rx_hold is set a long stall counted here so the
  // parser backs up and drops s_tready.
  initial begin
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      if (taken % 16 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          start_beats;
    int          pkt_num;
    int          kind;
    int          cut;
    logic [7:0]  first;
    logic        p_bit;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets: status codes, boundary sizes, precedence.
    send_rtp(8'h80, 0, 0, 0, 1, -1);             // one byte: first and last
    send_rtp(8'h80, 0, 0, 0, 11, -1);            // one short of a header
    send_rtp(8'hFF, 0, 0, 0, 11, -1);            // short wins over version
    send_rtp(8'h80, 0, 0, 0, -1, -1);            // bare 12-byte header
    send_rtp(8'h00, 0, 4, 0, -1, -1);            // version 0
    send_rtp(8'h40, 0, 4, 0, -1, -1);            // version 1
    send_rtp(8'hC0, 0, 4, 0, -1, -1);            // version 3
    send_rtp(8'hA0, 0, 0, 0, 12, 1);             // padding one past the header
    send_rtp(8'hA0, 0, 0, 0, 20, 255);           // max padding count, too long
    send_rtp(8'hA0, 0, 5, 0, -1, 0);             // P set, padding count zero
    send_rtp(8'hA0, 0, 3, 9, -1, -1);            // ordinary padding
    send_rtp(8'hA0, 0, 0, 8, -1, -1);            // padding eats all but header
    send_rtp(8'hBF, 0, 0, 255, -1, -1);          // 255 padding bytes, full CSRCs
    send_rtp(8'h8F, 0, 0, 0, 40, -1);            // CSRC list overruns
    send_rtp(8'hA2, 0, 0, 6, 22, 6);             // CSRC overrun after padding
    send_rtp(8'h8F, 0, 6, 0, -1, -1);            // 15 CSRCs, fits
    send_rtp(8'h90, 0, 0, 0, 14, -1);            // extension header cut off
    send_rtp(8'h90, 2, 0, 0, 18, -1);            // extension body cut off
    send_rtp(8'h90, 16'hFFFF, 0, 0, 30, -1);     // largest extension length
    send_rtp(8'h90, 0, 0, 0, -1, -1);            // empty extension body
    send_rtp(8'h90, 1, 7, 0, -1, -1);            // extension fits
    send_rtp(8'hB3, 2, 10, 5, -1, -1);           // CSRCs, extension, padding

    // Random part: mostly well-formed packets with random content, mixed with
    // truncated or re-tailed packets and raw noise.
    start_beats = tx_beats;
    pkt_num     = 0;
    while (tx_beats - start_beats < RANDOM_BEATS) begin
      if (pkt_num == 5 || pkt_num == 45) rx_hold = HOLD_CYCLES;
      kind  = $urandom_range(0, 99);
      p_bit = 1'($urandom);
      first = {2'b10, p_bit, 1'($urandom),
               4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(0, 3))};
      if (kind < 70) begin
        build_rtp(first, $urandom_range(0, 3), $urandom_range(0, 40),
                  p_bit ? $urandom_range(1, 12) : 0, -1,
                  (p_bit && $urandom_range(0, 7) == 0) ? 0 : -1);
      end else if (kind < 88) begin
        build_rtp(first, $urandom_range(0, 3), $urandom_range(0, 20),
                  p_bit ? $urandom_range(1, 12) : 0, -1, -1);
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
        if ($urandom_range(0, 1) == 0) pkt[pkt.size() - 1] = 8'($urandom);
      end else begin
        build_rtp(8'($urandom), $urandom_range(0, 2), $urandom_range(0, 20),
                  0, $urandom_range(1, 40), -1);
      end
      send_packet();
      pkt_num++;
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
